// ----- hw/rtl/b64e_pkg.sv -----
// shared types, constants and alphabet function for the base64 stream encoder
package b64e_pkg;

  localparam int unsigned CharW      = 8;
  localparam int unsigned MaxChars   = 4;
  localparam int unsigned CntW       = 3;
  localparam int unsigned IdxW       = 2;
  localparam int unsigned CfgAddrW   = 3;
  localparam int unsigned CfgDataW   = 32;

  localparam logic [7:0] GPL_RESET  = 8'd18;
  localparam logic [7:0] CHAR_PAD   = 8'h3D;
  localparam logic [7:0] CHAR_NL    = 8'h0A;

  localparam logic [0:0] REG_GPL    = 1'b0;

  typedef enum logic [1:0] {
    PH_0 = 2'd0,
    PH_1 = 2'd1,
    PH_2 = 2'd2
  } phase_t;

  typedef struct packed {
    logic [MaxChars-1:0][CharW-1:0] chars;
    logic [CntW-1:0]                cnt;
  } result_t;

  typedef struct packed {
    phase_t phase;
    logic   count_zero;
    logic   carry_zero;
  } enc_status_t;

  function automatic logic [7:0] sym(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

endpackage

// ----- hw/rtl/b64e_encode.sv -----
// group state and character generation for one input transaction
module b64e_encode (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic [7:0]           data_byte,
  input  logic                 flush,
  input  logic [7:0]           groups_per_line,
  output b64e_pkg::result_t    result,
  output b64e_pkg::enc_status_t status
);

  b64e_pkg::phase_t phase_r, phase_nxt;
  logic [5:0] carry_r, carry_nxt;
  logic [7:0] gcount_r, gcount_nxt;
  logic [7:0] gcount_inc;
  logic       wrap;

  assign gcount_inc = gcount_r + 8'd1;
  assign wrap       = (gcount_inc == groups_per_line);

  // next state
  always_comb begin
    phase_nxt  = phase_r;
    carry_nxt  = carry_r;
    gcount_nxt = gcount_r;
    if (accept) begin
      if (flush) begin
        phase_nxt  = b64e_pkg::PH_0;
        carry_nxt  = 6'd0;
        gcount_nxt = 8'd0;
      end else begin
        case (phase_r)
          b64e_pkg::PH_1: begin
            phase_nxt = b64e_pkg::PH_2;
            carry_nxt = {data_byte[3:0], 2'b00};
          end
          b64e_pkg::PH_2: begin
            phase_nxt  = b64e_pkg::PH_0;
            carry_nxt  = 6'd0;
            gcount_nxt = wrap ? 8'd0 : gcount_inc;
          end
          default: begin
            phase_nxt = b64e_pkg::PH_1;
            carry_nxt = {data_byte[1:0], 4'b0000};
          end
        endcase
      end
    end
  end

  // characters for this transaction
  always_comb begin
    result.chars = '0;
    result.cnt   = 3'd1;
    if (flush) begin
      case (phase_r)
        b64e_pkg::PH_1: begin
          result.chars[0] = b64e_pkg::sym(carry_r);
          result.chars[1] = b64e_pkg::CHAR_PAD;
          result.chars[2] = b64e_pkg::CHAR_PAD;
          result.chars[3] = b64e_pkg::CHAR_NL;
          result.cnt      = 3'd4;
        end
        b64e_pkg::PH_2: begin
          result.chars[0] = b64e_pkg::sym(carry_r);
          result.chars[1] = b64e_pkg::CHAR_PAD;
          result.chars[2] = b64e_pkg::CHAR_NL;
          result.cnt      = 3'd3;
        end
        default: begin
          result.chars[0] = b64e_pkg::CHAR_NL;
          result.cnt      = 3'd1;
        end
      endcase
    end else begin
      case (phase_r)
        b64e_pkg::PH_1: begin
          result.chars[0] = b64e_pkg::sym(carry_r | {2'b00, data_byte[7:4]});
          result.cnt      = 3'd1;
        end
        b64e_pkg::PH_2: begin
          result.chars[0] = b64e_pkg::sym(carry_r | {4'b0000, data_byte[7:6]});
          result.chars[1] = b64e_pkg::sym(data_byte[5:0]);
          result.chars[2] = b64e_pkg::CHAR_NL;
          result.cnt      = wrap ? 3'd3 : 3'd2;
        end
        default: begin
          result.chars[0] = b64e_pkg::sym(data_byte[7:2]);
          result.cnt      = 3'd1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= b64e_pkg::PH_0;
      carry_r  <= 6'd0;
      gcount_r <= 8'd0;
    end else begin
      phase_r  <= phase_nxt;
      carry_r  <= carry_nxt;
      gcount_r <= gcount_nxt;
    end
  end

  assign status.phase      = phase_r;
  assign status.count_zero = (gcount_r == 8'd0);
  assign status.carry_zero = (carry_r == 6'd0);

endmodule

// ----- hw/rtl/b64e_serializer.sv -----
// result buffer that sends the characters of one transaction one per cycle while out_tready is high
module b64e_serializer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  b64e_pkg::result_t result,
  output logic              can_load,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,
  output logic              out_tlast
);

  logic [b64e_pkg::MaxChars-1:0][b64e_pkg::CharW-1:0] chars_r;
  logic [b64e_pkg::CntW-1:0] rem_r, rem_nxt;
  logic [b64e_pkg::IdxW-1:0] idx_r, idx_nxt;
  logic                      take;

  assign out_tvalid = (rem_r != 3'd0);
  assign out_tlast  = (rem_r == 3'd1);
  assign out_tdata  = chars_r[idx_r];
  assign take       = out_tvalid && out_tready;
  assign can_load   = (rem_r == 3'd0) || (out_tlast && out_tready);

  always_comb begin
    rem_nxt = rem_r;
    idx_nxt = idx_r;
    if (load) begin
      rem_nxt = result.cnt;
      idx_nxt = 2'd0;
    end else if (take) begin
      rem_nxt = rem_r - 3'd1;
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= 3'd0;
      idx_r <= 2'd0;
    end else begin
      rem_r <= rem_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      chars_r <= result.chars;
    end
  end

endmodule

// ----- hw/rtl/base64_stream_encoder_core.sv -----
// base64 stream encoder top level with line wrap and config register
// Each input transaction is one raw byte or, with in_tuser high, a flush that
// pads the pending group with '=' and ends the line. The input side takes a
// new transaction in the same cycle the last character of the previous one
// leaves, so a byte that yields one character runs at one per cycle while
// out_tready stays high. The output buffer sends one character per cycle
// while out_tready is high; an item yields 1 character for the first and
// second byte of a group, 2 for the third (3 when a line-wrap newline follows)
// and 1 to 4 for a flush. Register 0 at byte address 0 sets groups_per_line
// (reset 18); 0 wraps every 256 groups. Write it only while the block is idle.
module base64_stream_encoder_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tuser,   // [0] flush
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_char
  output logic       out_tlast,
  input  logic       psel,
  input  logic       penable,
  input  logic       pwrite,
  input  logic [b64e_pkg::CfgAddrW-1:0] paddr,
  input  logic [b64e_pkg::CfgDataW-1:0] pwdata,
  output logic [b64e_pkg::CfgDataW-1:0] prdata,
  output logic       pready
);

  logic [7:0]            gpl_r;
  logic                  cfg_wr;
  logic                  in_acc;
  b64e_pkg::result_t     result;
  b64e_pkg::enc_status_t status;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == b64e_pkg::REG_GPL);
  assign prdata = (paddr[2] == b64e_pkg::REG_GPL) ? {24'd0, gpl_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gpl_r <= b64e_pkg::GPL_RESET;
    end else if (cfg_wr) begin
      gpl_r <= pwdata[7:0];
    end
  end

  assign in_acc = in_tvalid && in_tready;

  b64e_encode u_encode (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (in_acc),
    .data_byte       (in_tdata),
    .flush           (in_tuser),
    .groups_per_line (gpl_r),
    .result          (result),
    .status          (status)
  );

  b64e_serializer u_serializer (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (in_acc),
    .result     (result),
    .can_load   (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // input only taken when the buffer is empty or its last character leaves
  a_ready_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready && out_tvalid |-> out_tlast && out_tready)
    else $error("input taken while characters still pending");

  // every transaction produces at least one character
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_tvalid)
    else $error("transaction produced no character");

  // a flush returns the group state to its start
  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tuser |=> status.phase == b64e_pkg::PH_0 && status.count_zero
      && status.carry_zero)
    else $error("flush left group state behind");

endmodule
